FILE: hw/rtl/iob_pkg.sv
// Package: shared types, register offsets and helpers for the I/O register block.
`timescale 1ns / 1ps

package iob_pkg;

    // Sizes
    localparam int RX_DEPTH     = 64;
    localparam int RX_AW        = $clog2(RX_DEPTH);
    localparam int RX_CW        = $clog2(RX_DEPTH + 1);
    localparam int WINDOW_BYTES = 256;

    // Command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_RX    = 2'd3;

    // Register offsets inside the window
    localparam logic [15:0] REG_DATA      = 16'h0000;
    localparam logic [15:0] REG_STATUS    = 16'h0004;
    localparam logic [15:0] REG_UCTRL     = 16'h0008;
    localparam logic [15:0] REG_RXCNT     = 16'h000C;
    localparam logic [15:0] REG_STAMP_LO  = 16'h0014;
    localparam logic [15:0] REG_STAMP_HI  = 16'h0018;
    localparam logic [15:0] REG_WMARK     = 16'h001C;
    localparam logic [15:0] REG_PIN_OUT   = 16'h0024;
    localparam logic [15:0] REG_PIN_DIR   = 16'h0028;
    localparam logic [15:0] REG_TICK_LO   = 16'h0040;
    localparam logic [15:0] REG_TICK_HI   = 16'h0044;
    localparam logic [15:0] REG_T0_RELOAD = 16'h0048;
    localparam logic [15:0] REG_T0_COUNT  = 16'h004C;
    localparam logic [15:0] REG_T0_CTRL   = 16'h0050;
    localparam logic [15:0] REG_T0_STAT   = 16'h0054;
    localparam logic [15:0] REG_T1_RELOAD = 16'h0058;
    localparam logic [15:0] REG_T1_COUNT  = 16'h005C;
    localparam logic [15:0] REG_T1_CTRL   = 16'h0060;
    localparam logic [15:0] REG_T1_STAT   = 16'h0064;
    localparam logic [15:0] REG_IRQ_EN    = 16'h0070;
    localparam logic [15:0] REG_IRQ_PEND  = 16'h0074;
    localparam logic [15:0] REG_IRQ_MASK  = 16'h0078;

    // UART control bits
    localparam int UCTRL_TX_EN    = 0;
    localparam int UCTRL_STAMP_EN = 3;
    localparam int UCTRL_CLR_OVF  = 4;

    // Timer mode and control bits
    localparam int TMODE_EN     = 0;
    localparam int TMODE_RELOAD = 1;
    localparam int TCTRL_LOAD   = 2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
    } in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       in_window;
        logic       tx_valid;
        logic [7:0] tx_data;
    } out_t;

    // Replace one byte lane of a 32-bit word
    function automatic logic [31:0] merge_lane(input logic [31:0] old,
                                               input logic [7:0]  v,
                                               input logic [1:0]  lane);
        logic [4:0]  sh;
        logic [31:0] mask;
        sh   = {lane, 3'b000};
        mask = 32'h0000_00FF << sh;
        return (old & ~mask) | ({24'h0, v} << sh);
    endfunction

endpackage

FILE: hw/rtl/io_block_uart_fifo_timers_irq.sv
// Top level: byte-wide register window with UART receive FIFO, two timers, tick counter, IRQs.
`timescale 1ns / 1ps

// One request is accepted every cycle while results are being taken. All register
// state updates in the accept cycle; the receive FIFO sits in a 64 x 8 synchronous
// memory whose registered read port loads each popped byte as its request enters the
// holding stage. A holding stage in front of the output register lets the block keep
// accepting while one result waits. The user must write base_address through
// cfg_wr_en / cfg_wr_data only while the block is idle; the block does not enforce it.
module io_block_uart_fifo_timers_irq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  iob_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output iob_pkg::out_t  m_data
);
    import iob_pkg::*;

    // Architectural state
    logic [15:0]      base_reg;
    logic [RX_CW-1:0] rx_count_reg, rx_count_next;
    logic [RX_AW-1:0] rx_head_reg, rx_head_next;
    logic             rx_ovf_reg, rx_ovf_next;
    logic [63:0]      rx_stamp_reg, rx_stamp_next;
    logic [31:0]      uctrl_reg, uctrl_next;
    logic [31:0]      wmark_reg, wmark_next;
    logic [31:0]      pin_out_reg, pin_out_next;
    logic [31:0]      pin_dir_reg, pin_dir_next;
    logic [63:0]      tick_reg, tick_next;
    logic [31:0]      t_reload_reg [2], t_reload_next [2];
    logic [31:0]      t_count_reg [2], t_count_next [2];
    logic [1:0]       t_mode_reg [2], t_mode_next [2];
    logic             t_exp_reg [2], t_exp_next [2];
    logic [31:0]      irq_en_reg, irq_en_next;
    logic [31:0]      irq_mask_reg, irq_mask_next;

    // Receive memory
    logic [7:0]       rx_mem [RX_DEPTH];
    logic [7:0]       mem_q_reg;
    logic             mem_we, mem_re;
    logic [RX_AW-1:0] mem_waddr;

    // Pipeline
    logic   b_valid_reg, b_valid_next;
    out_t   b_data_reg, b_data_next;
    logic   b_pop_reg, b_pop_next;
    logic   b_move;
    logic   m_valid_reg, m_valid_next;
    out_t   m_data_reg;
    out_t   b_resolved;
    logic   acc;

    // Decode
    logic [15:0] win_end;
    logic [15:0] off;
    logic [15:0] reg_off;
    logic [1:0]  lane;
    logic        hit;
    logic        t_sel;
    logic [31:0] rd_word;
    logic [31:0] pend_word;
    logic [31:0] uctrl_merged;
    logic [31:0] t_reload_sel;

    // Handshake
    assign b_move  = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !b_valid_reg || b_move;
    assign acc     = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Window hit and offset
    assign win_end = 16'(({1'b0, base_reg} + 17'(WINDOW_BYTES)));
    assign hit     = (s_data.address >= base_reg) && (s_data.address < win_end);
    assign off     = s_data.address - base_reg;
    assign reg_off = {off[15:2], 2'b00};
    assign lane    = off[1:0];
    assign t_sel   = (reg_off >= REG_T1_RELOAD);
    assign t_reload_sel = t_reload_reg[t_sel];

    // Pending word
    always_comb begin
        pend_word = '0;
        pend_word[0] = (wmark_reg[7:0] != 8'h00) &&
                       ({{(8 - RX_CW){1'b0}}, rx_count_reg} >= wmark_reg[7:0]);
        pend_word[1] = (wmark_reg[15:8] != 8'h00);
        pend_word[4] = t_exp_reg[0];
        pend_word[5] = t_exp_reg[1];
    end

    // Read mux
    always_comb begin
        unique case (reg_off)
            REG_STATUS:    rd_word = {29'h0, rx_ovf_reg, 1'b1, (rx_count_reg != '0)};
            REG_UCTRL:     rd_word = uctrl_reg;
            REG_RXCNT:     rd_word = 32'(rx_count_reg);
            REG_STAMP_LO:  rd_word = rx_stamp_reg[31:0];
            REG_STAMP_HI:  rd_word = rx_stamp_reg[63:32];
            REG_WMARK:     rd_word = wmark_reg;
            REG_PIN_OUT:   rd_word = pin_out_reg;
            REG_PIN_DIR:   rd_word = pin_dir_reg;
            REG_TICK_LO:   rd_word = tick_reg[31:0];
            REG_TICK_HI:   rd_word = tick_reg[63:32];
            REG_T0_RELOAD: rd_word = t_reload_reg[0];
            REG_T0_COUNT:  rd_word = t_count_reg[0];
            REG_T0_CTRL:   rd_word = {30'h0, t_mode_reg[0]};
            REG_T0_STAT:   rd_word = {31'h0, t_exp_reg[0]};
            REG_T1_RELOAD: rd_word = t_reload_reg[1];
            REG_T1_COUNT:  rd_word = t_count_reg[1];
            REG_T1_CTRL:   rd_word = {30'h0, t_mode_reg[1]};
            REG_T1_STAT:   rd_word = {31'h0, t_exp_reg[1]};
            REG_IRQ_EN:    rd_word = irq_en_reg;
            REG_IRQ_PEND:  rd_word = pend_word;
            REG_IRQ_MASK:  rd_word = irq_mask_reg;
            default:       rd_word = '0;
        endcase
    end

    assign uctrl_merged = merge_lane(uctrl_reg, s_data.write_data, lane);

    // Request execution: register updates and memory access
    always_comb begin
        rx_count_next = rx_count_reg;
        rx_head_next  = rx_head_reg;
        rx_ovf_next   = rx_ovf_reg;
        rx_stamp_next = rx_stamp_reg;
        uctrl_next    = uctrl_reg;
        wmark_next    = wmark_reg;
        pin_out_next  = pin_out_reg;
        pin_dir_next  = pin_dir_reg;
        tick_next     = tick_reg;
        irq_en_next   = irq_en_reg;
        irq_mask_next = irq_mask_reg;
        for (int t = 0; t < 2; t++) begin
            t_reload_next[t] = t_reload_reg[t];
            t_count_next[t]  = t_count_reg[t];
            t_mode_next[t]   = t_mode_reg[t];
            t_exp_next[t]    = t_exp_reg[t];
        end
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = rx_head_reg + rx_count_reg[RX_AW-1:0];
        b_data_next = '0;
        b_pop_next  = 1'b0;

        if (acc) begin
            unique case (s_data.command)
                CMD_READ: begin
                    if (hit) begin
                        b_data_next.in_window = 1'b1;
                        if (reg_off == REG_DATA) begin
                            // lane 0 pops; upper lanes read zero
                            if (lane == 2'd0 && rx_count_reg != '0) begin
                                mem_re        = 1'b1;
                                b_pop_next    = 1'b1;
                                rx_head_next  = rx_head_reg + RX_AW'(1);
                                rx_count_next = rx_count_reg - RX_CW'(1);
                            end
                        end else begin
                            b_data_next.read_data = 8'(rd_word >> {lane, 3'b000});
                        end
                    end
                end
                CMD_WRITE: begin
                    if (hit) begin
                        b_data_next.in_window = 1'b1;
                        unique case (reg_off) inside
                            REG_DATA: begin
                                if (lane == 2'd0 && uctrl_reg[UCTRL_TX_EN]) begin
                                    b_data_next.tx_valid = 1'b1;
                                    b_data_next.tx_data  = s_data.write_data;
                                end
                            end
                            REG_UCTRL: begin
                                uctrl_next = uctrl_merged;
                                if (uctrl_merged[UCTRL_CLR_OVF]) begin
                                    rx_ovf_next = 1'b0;
                                    uctrl_next[UCTRL_CLR_OVF] = 1'b0;
                                end
                            end
                            REG_WMARK:
                                wmark_next = merge_lane(wmark_reg, s_data.write_data, lane);
                            REG_PIN_OUT:
                                pin_out_next = merge_lane(pin_out_reg, s_data.write_data, lane);
                            REG_PIN_DIR:
                                pin_dir_next = merge_lane(pin_dir_reg, s_data.write_data, lane);
                            REG_T0_RELOAD, REG_T1_RELOAD:
                                t_reload_next[t_sel] =
                                    merge_lane(t_reload_sel, s_data.write_data, lane);
                            REG_T0_CTRL, REG_T1_CTRL: begin
                                if (lane == 2'd0) begin
                                    t_mode_next[t_sel] = s_data.write_data[1:0];
                                    if (s_data.write_data[TCTRL_LOAD]) begin
                                        t_count_next[t_sel] = t_reload_sel;
                                    end
                                end
                            end
                            REG_T0_STAT, REG_T1_STAT:
                                t_exp_next[t_sel] = 1'b0;
                            REG_IRQ_EN:
                                irq_en_next = merge_lane(irq_en_reg, s_data.write_data, lane);
                            REG_IRQ_MASK:
                                irq_mask_next = merge_lane(irq_mask_reg, s_data.write_data, lane);
                            default: ;
                        endcase
                    end
                end
                CMD_TICK: begin
                    tick_next = tick_reg + 64'd1;
                    for (int t = 0; t < 2; t++) begin
                        if (t_mode_reg[t][TMODE_EN]) begin
                            if (t_count_reg[t] == '0) begin
                                t_exp_next[t] = 1'b1;
                                if (t_mode_reg[t][TMODE_RELOAD]) begin
                                    t_count_next[t] = t_reload_reg[t];
                                end else begin
                                    t_mode_next[t][TMODE_EN] = 1'b0;
                                end
                            end else begin
                                t_count_next[t] = t_count_reg[t] - 32'd1;
                            end
                        end
                    end
                end
                CMD_RX: begin
                    if (rx_count_reg >= RX_CW'(RX_DEPTH)) begin
                        rx_ovf_next = 1'b1;
                    end else begin
                        mem_we        = 1'b1;
                        rx_count_next = rx_count_reg + RX_CW'(1);
                        if (uctrl_reg[UCTRL_STAMP_EN]) begin
                            rx_stamp_next = tick_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Holding stage and output register control
    always_comb begin
        b_valid_next = acc ? 1'b1 : (b_move ? 1'b0 : b_valid_reg);
        m_valid_next = b_move || (m_valid_reg && !m_ready);
        b_resolved   = b_data_reg;
        if (b_pop_reg) begin
            b_resolved.read_data = mem_q_reg;
        end
    end

    // Receive memory: a pop always reads an entry written by an earlier request,
    // so no bypass is needed. The read register only loads on a pop, and a pop is only
    // accepted when the holding stage drains, so a stalled popped byte stays put.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rx_mem[mem_waddr] <= s_data.write_data;
        end
        if (mem_re) begin
            mem_q_reg <= rx_mem[rx_head_reg];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (acc) begin
            b_data_reg <= b_data_next;
            b_pop_reg  <= b_pop_next;
        end
        if (b_move) begin
            m_data_reg <= b_resolved;
        end
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            rx_count_reg <= '0;
            rx_head_reg  <= '0;
            rx_ovf_reg   <= 1'b0;
            rx_stamp_reg <= '0;
            uctrl_reg    <= '0;
            wmark_reg    <= '0;
            pin_out_reg  <= '0;
            pin_dir_reg  <= '0;
            tick_reg     <= '0;
            irq_en_reg   <= '0;
            irq_mask_reg <= '0;
            for (int t = 0; t < 2; t++) begin
                t_reload_reg[t] <= '0;
                t_count_reg[t]  <= '0;
                t_mode_reg[t]   <= '0;
                t_exp_reg[t]    <= 1'b0;
            end
            b_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            rx_count_reg <= rx_count_next;
            rx_head_reg  <= rx_head_next;
            rx_ovf_reg   <= rx_ovf_next;
            rx_stamp_reg <= rx_stamp_next;
            uctrl_reg    <= uctrl_next;
            wmark_reg    <= wmark_next;
            pin_out_reg  <= pin_out_next;
            pin_dir_reg  <= pin_dir_next;
            tick_reg     <= tick_next;
            irq_en_reg   <= irq_en_next;
            irq_mask_reg <= irq_mask_next;
            for (int t = 0; t < 2; t++) begin
                t_reload_reg[t] <= t_reload_next[t];
                t_count_reg[t]  <= t_count_next[t];
                t_mode_reg[t]   <= t_mode_next[t];
                t_exp_reg[t]    <= t_exp_next[t];
            end
            b_valid_reg  <= b_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

`ifndef SYNTH
    // FIFO fill never exceeds its depth
    a_rx_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_count_reg <= RX_CW'(RX_DEPTH))
        else $error("rx count above depth");

    // A stalled popped byte keeps its memory read data
    a_mem_q_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_pop_reg && !b_move) |=> $stable(mem_q_reg))
        else $error("popped byte lost while stalled");

    // A pop lowers the fill by one
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |=> (rx_count_reg == $past(rx_count_reg) - RX_CW'(1)))
        else $error("pop did not decrement rx count");

    // Overflow is raised only by a receive into a full FIFO
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(rx_ovf_reg) |-> ($past(rx_count_reg) == RX_CW'(RX_DEPTH)))
        else $error("overflow set while FIFO not full");

    // A memory write and a pop never share a cycle
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("receive and pop in one cycle");
`endif

endmodule

FILE: dv/tb_io_block_uart_fifo_timers_irq.sv
// Testbench: drives random and directed bus, tick and receive requests and checks each response.
`timescale 1ns / 1ps

module tb_io_block_uart_fifo_timers_irq;
    import iob_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam bit FIXED   = 1'b1;
    localparam bit PREDICT = 1'b0;

    // Directed row: request plus an optional hand-written response
    typedef struct packed {
        in_t  req;
        logic fixed;
        out_t want;
    } probe_row_t;

    logic  aclk = 1'b0;
    logic  aresetn;
    logic  cfg_wr_en;
    logic  [15:0] cfg_wr_data;
    logic  s_valid;
    logic  s_ready;
    in_t   s_data;
    logic  m_valid;
    logic  m_ready;
    out_t  m_data;

    // Shadow copy of the register window
    logic [15:0] sh_base;
    logic [7:0]  sh_rx_mem [RX_DEPTH];
    logic [6:0]  sh_rx_cnt;
    logic [5:0]  sh_rx_head;
    logic        sh_rx_ovf;
    logic [63:0] sh_rx_stamp;
    logic [31:0] sh_uctrl;
    logic [31:0] sh_wmark;
    logic [31:0] sh_pin_out;
    logic [31:0] sh_pin_dir;
    logic [63:0] sh_ticks;
    logic [31:0] sh_t_reload [2];
    logic [31:0] sh_t_count [2];
    logic [1:0]  sh_t_mode [2];
    logic        sh_t_expired [2];
    logic [31:0] sh_irq_en;
    logic [31:0] sh_irq_mask;

    out_t        resp_due [$];
    probe_row_t  probe_tab [$];
    out_t        want;
    int unsigned err_count = 0;
    int unsigned sent_items = 0;
    int unsigned idle_cycles = 0;
    int unsigned rdy_hold = 0;
    int unsigned rdy_len;
    bit          quiet = 1'b0;

    io_block_uart_fifo_timers_irq dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        err_count++;
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] win_addr(input logic [15:0] off);
        return sh_base + off;
    endfunction

    function void shadow_reset();
        sh_base     = '0;
        sh_rx_cnt   = '0;
        sh_rx_head  = '0;
        sh_rx_ovf   = 1'b0;
        sh_rx_stamp = '0;
        sh_uctrl    = '0;
        sh_wmark    = '0;
        sh_pin_out  = '0;
        sh_pin_dir  = '0;
        sh_ticks    = '0;
        sh_irq_en   = '0;
        sh_irq_mask = '0;
        for (int t = 0; t < 2; t++) begin
            sh_t_reload[t]  = '0;
            sh_t_count[t]   = '0;
            sh_t_mode[t]    = '0;
            sh_t_expired[t] = 1'b0;
        end
    endfunction

    // Full 32-bit value of a readable register
    function automatic logic [31:0] shadow_word(input logic [15:0] r);
        logic [31:0] w;
        w = '0;
        case (r)
            REG_STATUS:    w = {29'h0, sh_rx_ovf, 1'b1, sh_rx_cnt != 0};
            REG_UCTRL:     w = sh_uctrl;
            REG_RXCNT:     w = {25'h0, sh_rx_cnt};
            REG_STAMP_LO:  w = sh_rx_stamp[31:0];
            REG_STAMP_HI:  w = sh_rx_stamp[63:32];
            REG_WMARK:     w = sh_wmark;
            REG_PIN_OUT:   w = sh_pin_out;
            REG_PIN_DIR:   w = sh_pin_dir;
            REG_TICK_LO:   w = sh_ticks[31:0];
            REG_TICK_HI:   w = sh_ticks[63:32];
            REG_T0_RELOAD: w = sh_t_reload[0];
            REG_T0_COUNT:  w = sh_t_count[0];
            REG_T0_CTRL:   w = {30'h0, sh_t_mode[0]};
            REG_T0_STAT:   w = {31'h0, sh_t_expired[0]};
            REG_T1_RELOAD: w = sh_t_reload[1];
            REG_T1_COUNT:  w = sh_t_count[1];
            REG_T1_CTRL:   w = {30'h0, sh_t_mode[1]};
            REG_T1_STAT:   w = {31'h0, sh_t_expired[1]};
            REG_IRQ_EN:    w = sh_irq_en;
            REG_IRQ_PEND: begin
                // enable and mask words do not gate pending bits
                if (sh_wmark[7:0] != 0 && {1'b0, sh_rx_cnt} >= sh_wmark[7:0]) w[0] = 1'b1;
                if (sh_wmark[15:8] != 0) w[1] = 1'b1;
                w[4] = sh_t_expired[0];
                w[5] = sh_t_expired[1];
            end
            REG_IRQ_MASK:  w = sh_irq_mask;
            default:       w = '0;
        endcase
        return w;
    endfunction

    // Byte-lane write into the shadow registers
    function void shadow_write(input logic [15:0] r, input logic [7:0] v, input logic [1:0] lane);
        case (r)
            REG_UCTRL: begin
                sh_uctrl[{lane, 3'b000} +: 8] = v;
                if (sh_uctrl[UCTRL_CLR_OVF]) begin
                    sh_rx_ovf = 1'b0;
                    sh_uctrl[UCTRL_CLR_OVF] = 1'b0;
                end
            end
            REG_WMARK:     sh_wmark[{lane, 3'b000} +: 8] = v;
            REG_PIN_OUT:   sh_pin_out[{lane, 3'b000} +: 8] = v;
            REG_PIN_DIR:   sh_pin_dir[{lane, 3'b000} +: 8] = v;
            REG_T0_RELOAD: sh_t_reload[0][{lane, 3'b000} +: 8] = v;
            REG_T1_RELOAD: sh_t_reload[1][{lane, 3'b000} +: 8] = v;
            REG_T0_CTRL, REG_T1_CTRL: begin
                // only lane 0 of a timer control acts
                if (lane == 2'd0) begin
                    sh_t_mode[r == REG_T1_CTRL] = v[1:0];
                    if (v[TCTRL_LOAD])
                        sh_t_count[r == REG_T1_CTRL] = sh_t_reload[r == REG_T1_CTRL];
                end
            end
            REG_T0_STAT:   sh_t_expired[0] = 1'b0;
            REG_T1_STAT:   sh_t_expired[1] = 1'b0;
            REG_IRQ_EN:    sh_irq_en[{lane, 3'b000} +: 8] = v;
            REG_IRQ_MASK:  sh_irq_mask[{lane, 3'b000} +: 8] = v;
            default: ;
        endcase
    endfunction

    // One tick: free-running counter plus both timers
    function void shadow_tick();
        sh_ticks = sh_ticks + 64'd1;
        for (int t = 0; t < 2; t++) begin
            if (sh_t_mode[t][TMODE_EN]) begin
                if (sh_t_count[t] == 0) begin
                    sh_t_expired[t] = 1'b1;
                    if (sh_t_mode[t][TMODE_RELOAD]) sh_t_count[t] = sh_t_reload[t];
                    else sh_t_mode[t][TMODE_EN] = 1'b0;
                end else begin
                    sh_t_count[t] = sh_t_count[t] - 32'd1;
                end
            end
        end
    endfunction

    // Received byte: store, or flag overflow when full
    function void shadow_receive(input logic [7:0] b);
        if (sh_rx_cnt >= RX_DEPTH) begin
            sh_rx_ovf = 1'b1;
        end else begin
            sh_rx_mem[sh_rx_head + sh_rx_cnt[5:0]] = b;
            sh_rx_cnt = sh_rx_cnt + 7'd1;
            if (sh_uctrl[UCTRL_STAMP_EN]) sh_rx_stamp = sh_ticks;
        end
    endfunction

    // Applies one request to the shadow and returns the response it must produce
    function automatic out_t shadow_step(input in_t req);
        out_t        o;
        logic [15:0] lim;
        logic [15:0] off;
        logic [15:0] r;
        logic [1:0]  lane;
        logic [31:0] w;
        o = '0;
        case (req.command)
            CMD_READ, CMD_WRITE: begin
                lim = sh_base + 16'(WINDOW_BYTES);
                if (req.address >= sh_base && req.address < lim) begin
                    off  = req.address - sh_base;
                    r    = off & 16'hFFFC;
                    lane = off[1:0];
                    o.in_window = 1'b1;
                    if (req.command == CMD_READ) begin
                        if (r == REG_DATA) begin
                            // only lane 0 pops, and only when something is queued
                            if (lane == 2'd0 && sh_rx_cnt != 0) begin
                                o.read_data = sh_rx_mem[sh_rx_head];
                                sh_rx_head  = sh_rx_head + 6'd1;
                                sh_rx_cnt   = sh_rx_cnt - 7'd1;
                            end
                        end else begin
                            w = shadow_word(r);
                            o.read_data = w[{lane, 3'b000} +: 8];
                        end
                    end else if (r == REG_DATA) begin
                        if (lane == 2'd0 && sh_uctrl[UCTRL_TX_EN]) begin
                            o.tx_valid = 1'b1;
                            o.tx_data  = req.write_data;
                        end
                    end else begin
                        shadow_write(r, req.write_data, lane);
                    end
                end
            end
            CMD_TICK: shadow_tick();
            default:  shadow_receive(req.write_data);
        endcase
        return o;
    endfunction

    // Presents one request, waits for its acceptance, queues the expected response
    task automatic send_request(input in_t req, input logic fixed, input out_t fixed_resp);
        int unsigned gap;
        out_t        p;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        p = shadow_step(req);
        sent_items++;
        resp_due.insert(resp_due.size(), fixed ? fixed_resp : p);
    endtask

    task automatic issue(input logic [1:0] cmd, input logic [15:0] addr, input logic [7:0] wd);
        in_t r;
        r.command    = cmd;
        r.address    = addr;
        r.write_data = wd;
        send_request(r, PREDICT, '0);
    endtask

    function automatic probe_row_t probe(input logic [1:0] cmd, input logic [15:0] addr,
                                         input logic [7:0] wd, input logic fixed,
                                         input logic [7:0] rd, input logic hit,
                                         input logic txv, input logic [7:0] txd);
        probe_row_t row;
        row.req.command    = cmd;
        row.req.address    = addr;
        row.req.write_data = wd;
        row.fixed          = fixed;
        row.want.read_data = rd;
        row.want.in_window = hit;
        row.want.tx_valid  = txv;
        row.want.tx_data   = txd;
        return row;
    endfunction

    // Appends one row to the directed table
    function void add_row(input probe_row_t row);
        probe_tab.insert(probe_tab.size(), row);
    endfunction

    // Base register is only written once all responses are back
    task automatic set_base(input logic [15:0] value);
        s_valid <= 1'b0;
        while (resp_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sh_base = value;
    endtask

    function automatic logic [15:0] pick_rw_reg();
        case ($urandom_range(0, 9))
            0:       return REG_UCTRL;
            1:       return REG_WMARK;
            2:       return REG_PIN_OUT;
            3:       return REG_PIN_DIR;
            4:       return REG_T0_RELOAD;
            5:       return REG_T1_RELOAD;
            6:       return REG_IRQ_EN;
            7:       return REG_IRQ_MASK;
            8:       return REG_T0_CTRL;
            default: return REG_T1_CTRL;
        endcase
    endfunction

    // One random but mostly well-formed sequence of requests
    task automatic run_sequence();
        int unsigned n;
        logic        tsel;
        logic [15:0] r;
        logic [1:0]  lane;
        logic [7:0]  wd;
        quiet = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 9))
            0, 1: begin
                // receive burst, sometimes long enough to overflow, then drain a part
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
                repeat (n) issue(CMD_RX, $urandom, $urandom);
                issue(CMD_READ, win_addr(REG_RXCNT), $urandom);
                repeat ($urandom_range(1, n + 2)) issue(CMD_READ, win_addr(REG_DATA), $urandom);
                issue(CMD_READ, win_addr(REG_STATUS), $urandom);
                issue(CMD_READ, win_addr(REG_STAMP_LO | 16'($urandom_range(0, 3))), $urandom);
            end
            2, 3: begin
                // program a timer, let it run, look at it
                tsel = $urandom_range(0, 1);
                issue(CMD_WRITE, win_addr(tsel ? REG_T1_RELOAD : REG_T0_RELOAD),
                      $urandom_range(0, 5));
                if ($urandom_range(0, 3) == 0)
                    issue(CMD_WRITE, win_addr((tsel ? REG_T1_RELOAD : REG_T0_RELOAD)
                                              | 16'($urandom_range(1, 3))), $urandom);
                wd = $urandom;
                if ($urandom_range(0, 3) != 0) wd[TCTRL_LOAD] = 1'b1;
                issue(CMD_WRITE, win_addr(tsel ? REG_T1_CTRL : REG_T0_CTRL), wd);
                repeat ($urandom_range(0, 12)) issue(CMD_TICK, $urandom, $urandom);
                issue(CMD_READ, win_addr(tsel ? REG_T1_COUNT : REG_T0_COUNT), $urandom);
                issue(CMD_READ, win_addr(tsel ? REG_T1_STAT : REG_T0_STAT), $urandom);
                issue(CMD_READ, win_addr(REG_IRQ_PEND), $urandom);
                if ($urandom_range(0, 1))
                    issue(CMD_WRITE, win_addr((tsel ? REG_T1_STAT : REG_T0_STAT)
                                              | 16'($urandom_range(0, 3))), $urandom);
            end
            4: begin
                // uart control, watermarks, transmit
                lane = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
                issue(CMD_WRITE, win_addr(REG_UCTRL | 16'(lane)), $urandom);
                issue(CMD_WRITE, win_addr(REG_WMARK | 16'($urandom_range(0, 1))),
                      $urandom_range(0, 8));
                repeat ($urandom_range(1, 4)) begin
                    lane = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
                    issue(CMD_WRITE, win_addr(REG_DATA | 16'(lane)), $urandom);
                end
                issue(CMD_READ, win_addr(REG_IRQ_PEND), $urandom);
                issue(CMD_READ, win_addr(REG_STATUS), $urandom);
            end
            5, 6: begin
                // write one lane and read it back
                r    = pick_rw_reg();
                lane = $urandom_range(0, 3);
                issue(CMD_WRITE, win_addr(r | 16'(lane)), $urandom);
                issue(CMD_READ, win_addr(r | 16'(lane)), $urandom);
            end
            7: begin
                // reads anywhere in the window
                repeat ($urandom_range(1, 6)) issue(CMD_READ, win_addr($urandom_range(0, 255)),
                                                     $urandom);
            end
            default: begin
                // noise: any command, address in or out of the window
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 1))
                        issue($urandom, win_addr($urandom_range(0, 255)), $urandom);
                    else
                        issue($urandom, $urandom, $urandom);
                end
            end
        endcase
    endtask

    // Result side: random stalls, with stretches of none
    always @(posedge aclk) begin
        if (rdy_hold != 0) begin
            rdy_hold = rdy_hold - 1;
            m_ready <= 1'b0;
        end else begin
            rdy_len = (quiet || $urandom_range(0, 99) < 70) ? 0 : pick_gap();
            if (rdy_len == 0) begin
                m_ready <= 1'b1;
            end else begin
                rdy_hold = rdy_len - 1;
                m_ready <= 1'b0;
            end
        end
    end

    // Compare each response with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (resp_due.size() == 0) begin
                report_mismatch("response with no request outstanding", 32'(m_data), 0);
            end else begin
                want = resp_due[0];
                resp_due.delete(0);
                if (m_data.read_data !== want.read_data)
                    report_mismatch("read_data", m_data.read_data, want.read_data);
                if (m_data.in_window !== want.in_window)
                    report_mismatch("in_window", m_data.in_window, want.in_window);
                if (m_data.tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", m_data.tx_valid, want.tx_valid);
                if (m_data.tx_data !== want.tx_data)
                    report_mismatch("tx_data", m_data.tx_data, want.tx_data);
            end
        end
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : main_seq
        logic [15:0] phase_base [6];
        int unsigned phase_goal [6];
        int unsigned start;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        shadow_reset();

        // Directed requests, base at reset value 0
        add_row(probe(CMD_READ,  REG_STATUS,        8'h00, FIXED, 8'h02, 1, 0, 8'h00));
        add_row(probe(CMD_READ,  REG_DATA,          8'h00, FIXED, 8'h00, 1, 0, 8'h00));
        add_row(probe(CMD_READ,  REG_TICK_LO,       8'h00, FIXED, 8'h00, 1, 0, 8'h00));
        add_row(probe(CMD_WRITE, REG_DATA,          8'h5A, FIXED, 8'h00, 1, 0, 8'h00));
        add_row(probe(CMD_WRITE, REG_UCTRL,         8'h09, FIXED, 8'h00, 1, 0, 8'h00));
        add_row(probe(CMD_WRITE, REG_DATA,          8'hFF, FIXED, 8'h00, 1, 1, 8'hFF));
        add_row(probe(CMD_WRITE, REG_DATA + 16'd2,  8'h77, FIXED, 8'h00, 1, 0, 8'h00));
        add_row(probe(CMD_TICK,  16'h0000,          8'hFF, FIXED, 8'h00, 0, 0, 8'h00));
        add_row(probe(CMD_RX,    REG_STATUS,        8'hA5, FIXED, 8'h00, 0, 0, 8'h00));
        add_row(probe(CMD_RX,    16'hFFFF,          8'h00, FIXED, 8'h00, 0, 0, 8'h00));
        add_row(probe(CMD_READ,  REG_RXCNT,         8'h00, PREDICT, 0, 0, 0, 0));
        add_row(probe(CMD_READ,  REG_STAMP_LO,      8'h00, PREDICT, 0, 0, 0, 0));
        add_row(probe(CMD_READ,  REG_DATA + 16'd1,  8'h00, FIXED, 8'h00, 1, 0, 8'h00));
        add_row(probe(CMD_READ,  REG_DATA,          8'h00, FIXED, 8'hA5, 1, 0, 8'h00));
        add_row(probe(CMD_WRITE, REG_WMARK + 16'd1, 8'h01, FIXED, 8'h00, 1, 0, 8'h00));
        add_row(probe(CMD_READ,  REG_IRQ_PEND,      8'h00, PREDICT, 0, 0, 0, 0));
        add_row(probe(CMD_WRITE, REG_T0_RELOAD,     8'h01, FIXED, 8'h00, 1, 0, 8'h00));
        add_row(probe(CMD_WRITE, REG_T0_CTRL,       8'h07, FIXED, 8'h00, 1, 0, 8'h00));
        add_row(probe(CMD_TICK,  16'h1234,          8'h00, FIXED, 8'h00, 0, 0, 8'h00));
        add_row(probe(CMD_TICK,  16'h0000,          8'h00, FIXED, 8'h00, 0, 0, 8'h00));
        add_row(probe(CMD_READ,  REG_T0_STAT,       8'h00, PREDICT, 0, 0, 0, 0));
        add_row(probe(CMD_WRITE, REG_T0_STAT + 16'd3, 8'h00, FIXED, 8'h00, 1, 0, 8'h00));
        add_row(probe(CMD_READ,  16'hFFFF,          8'h00, FIXED, 8'h00, 0, 0, 8'h00));
        add_row(probe(CMD_WRITE, 16'h002E,          8'hFF, FIXED, 8'h00, 1, 0, 8'h00));
        add_row(probe(CMD_WRITE, REG_UCTRL,         8'h10, FIXED, 8'h00, 1, 0, 8'h00));

        // Random phases; two of the windows wrap past the top and answer nothing
        phase_base[0] = 16'h0000;  phase_goal[0] = 450;
        phase_base[1] = 16'hFFFF;  phase_goal[1] = 60;
        phase_base[2] = $urandom_range(1, 16'hFEFE);  phase_goal[2] = 350;
        phase_base[3] = 16'hFF00;  phase_goal[3] = 60;
        phase_base[4] = 16'hFEFF;  phase_goal[4] = 350;
        phase_base[5] = $urandom_range(1, 16'hFEFE);  phase_goal[5] = 350;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probe_tab[i]) send_request(probe_tab[i].req, probe_tab[i].fixed,
                                            probe_tab[i].want);

        for (int ph = 0; ph < 6; ph++) begin
            set_base(phase_base[ph]);
            start = sent_items;
            while (sent_items - start < phase_goal[ph]) run_sequence();
        end

        // Drain and let the pipeline settle
        s_valid <= 1'b0;
        quiet = 1'b0;
        while (resp_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
